[hdl/sbxfr_pkg.sv]
// Package for the sync-byte framed receiver.
// Holds the frame geometry and payload widths; depends on nothing.
`default_nettype none

package sbxfr_pkg;

   localparam int FRAME_BYTES = 7;                        // sync + body + check, 3 to 8
   localparam int BYTE_W      = 8;
   localparam int BODY_W      = 48;
   localparam int COUNT_W     = $clog2(FRAME_BYTES);
   localparam logic [BYTE_W-1:0]  SYNC_RESET = 8'hC1;
   localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(FRAME_BYTES - 1);

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_MISMATCH = 1'b1;

   typedef logic [BYTE_W-1:0]  byte_type;
   typedef logic [BODY_W-1:0]  body_type;
   typedef logic [COUNT_W-1:0] count_type;

endpackage

`default_nettype wire

[hdl/sbxfr_if.sv]
// Valid/ready channel interfaces for the receiver's byte input and frame output.
// Depends on sbxfr_pkg for the payload types.
`default_nettype none

interface sbxfr_req_if
   import sbxfr_pkg::*;
   ;
   logic     valid;
   logic     ready;
   byte_type rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sbxfr_rsp_if
   import sbxfr_pkg::*;
   ;
   logic     valid;
   logic     ready;
   logic     frame_status;
   body_type frame_body;

   modport source (output valid, output frame_status, output frame_body, input ready);
   modport sink   (input valid, input frame_status, input frame_body, output ready);
endinterface

`default_nettype wire

[hdl/sync_byte_xor_frame_receiver.sv]
// Top level of the sync-byte framed receiver with XOR-8 checksum.
// Depends on sbxfr_pkg and the channel interfaces in sbxfr_if.sv.
//
//   channel   direction   payload                          handshake
//   req_ch    in          rx_byte[7:0]                     valid/ready
//   rsp_ch    out         frame_status, frame_body[47:0]   valid/ready
//   csr       in          csr_wr_data[7:0] (sync value)    csr_wr_en, no wait
//
// One item per cycle is accepted while the frame logic does not stall; an item
// passes an input register and then the frame logic, which loads the result of a
// frame into the output register when it takes the frame's check byte.
// The frame logic stalls only when it must load a result while the output register
// still holds one that is not taken. Reset is synchronous and sets the sync value
// to 0xC1 and the receiver to hunting.
`default_nettype none

module sync_byte_xor_frame_receiver
   import sbxfr_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   sbxfr_req_if.sink   req_ch,
   sbxfr_rsp_if.source rsp_ch,
   input  wire logic   csr_wr_en,
   input  wire logic [BYTE_W-1:0] csr_wr_data
);

   byte_type  sync_ff;
   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff;
   logic      in_frame_ff, in_frame_in;
   count_type count_ff, count_in;
   byte_type  xor_ff, xor_in;
   body_type  body_ff, body_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      status_ff, status_in;
   body_type  rsp_body_ff, rsp_body_in;

   logic is_last;
   logic advance;
   logic rsp_load;

   // The check byte of a frame is the only item that needs the output register.
   assign is_last  = in_valid_ff && in_frame_ff && (count_ff >= LAST_COUNT);
   assign advance  = !is_last || !rsp_valid_ff || rsp_ch.ready;
   assign rsp_load = is_last && advance;

   assign req_ch.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_frame_in  = in_frame_ff;
      count_in     = count_ff;
      xor_in       = xor_ff;
      body_in      = body_ff;
      rsp_valid_in = rsp_valid_ff;
      status_in    = status_ff;
      rsp_body_in  = rsp_body_ff;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (in_valid_ff && advance) begin
         in_valid_in = 1'b0;
         if (!in_frame_ff) begin
            if (in_byte_ff == sync_ff) begin
               in_frame_in = 1'b1;
               count_in    = count_type'(1);
               xor_in      = in_byte_ff;
               body_in     = '0;
            end
         end else if (is_last) begin
            rsp_valid_in = 1'b1;
            status_in    = (xor_ff != in_byte_ff) ? STATUS_MISMATCH : STATUS_OK;
            rsp_body_in  = body_ff;
            in_frame_in  = 1'b0;
            count_in     = '0;
         end else begin
            xor_in   = xor_ff ^ in_byte_ff;
            body_in  = {body_ff[BODY_W-BYTE_W-1:0], in_byte_ff};
            count_in = count_ff + count_type'(1);
         end
      end

      if (req_ch.valid && req_ch.ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_ff      <= SYNC_RESET;
         in_valid_ff  <= 1'b0;
         in_frame_ff  <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            sync_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         in_frame_ff  <= in_frame_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_byte_ff <= req_ch.rx_byte;
      end
      xor_ff      <= xor_in;
      body_ff     <= body_in;
      status_ff   <= status_in;
      rsp_body_ff <= rsp_body_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frame_status = status_ff;
   assign rsp_ch.frame_body   = rsp_body_ff;

   // While hunting the byte counter sits at zero.
   a_count_idle: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> count_ff == '0)
      else $error("byte counter nonzero while hunting");

   // Inside a frame the counter stays between one and the check position.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      in_frame_ff |-> (count_ff != '0) && (count_ff <= LAST_COUNT))
      else $error("byte counter out of frame range");

   // Loading a result closes the frame and hunting resumes.
   a_load_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> !in_frame_ff && rsp_valid_ff)
      else $error("frame still open after its result was loaded");

   // A held input item is never dropped while the frame logic stalls.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("stalled input item lost");

endmodule

`default_nettype wire

[sim/tb_sync_byte_xor_frame_receiver.sv]
// Self-checking testbench for the sync-byte framed receiver with XOR-8 checksum.
// Needs sbxfr_pkg, the channel interfaces in sbxfr_if.sv and the receiver top level.
`default_nettype none

module tb_sync_byte_xor_frame_receiver;
   import sbxfr_pkg::*;

   localparam int DRAIN_CYCLES   = 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_ITEMS    = 460;

   typedef struct packed {
      logic     status;
      body_type body;
   } frame_result_type;

   logic     clock;
   logic     reset;
   logic     csr_wr_en;
   byte_type csr_wr_data;

   sbxfr_req_if req_ch ();
   sbxfr_rsp_if rsp_ch ();

   sync_byte_xor_frame_receiver dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Bytes waiting to be sent and frames the receiver still owes us.
   byte_type         rx_byte_q [$];
   frame_result_type frame_expect_q [$];

   // Predictor state, a copy of what the receiver should hold.
   byte_type         sync_now;
   bit               in_frame;
   int               frame_pos;
   byte_type         frame_xor;
   body_type         body_acc;

   int               send_idle_pct;
   int               recv_stall_pct;
   int               error_count;
   int               quiet_cycles;
   int               framed_items;
   int               phase_start;
   int               choice;
   byte_type         phase_sync;
   body_type         rand_body;
   frame_result_type oldest_frame;

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   task automatic predict_byte(input byte_type b);
      frame_result_type done;
      if (!in_frame) begin
         // Anything other than the sync byte is dropped while hunting.
         if (b == sync_now) begin
            in_frame  = 1'b1;
            frame_pos = 1;
            frame_xor = b;
            body_acc  = '0;
         end
      end else if (frame_pos >= FRAME_BYTES - 1) begin
         done.status = (frame_xor != b) ? STATUS_MISMATCH : STATUS_OK;
         done.body   = body_acc;
         frame_expect_q.push_back(done);
         in_frame  = 1'b0;
         frame_pos = 0;
         frame_xor = '0;
         body_acc  = '0;
      end else begin
         frame_xor = frame_xor ^ b;
         body_acc  = body_type'({body_acc, b});
         frame_pos = frame_pos + 1;
      end
   endtask

   // Byte sender and predictor. The predictor sees each item at the edge that accepts it.
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid   <= 1'b0;
         req_ch.rx_byte <= '0;
         sync_now  = SYNC_RESET;
         in_frame  = 1'b0;
         frame_pos = 0;
         frame_xor = '0;
         body_acc  = '0;
      end else begin
         if (csr_wr_en)
            sync_now = csr_wr_data;
         if (req_ch.valid && req_ch.ready)
            predict_byte(req_ch.rx_byte);
         if (!req_ch.valid || req_ch.ready) begin
            if (rx_byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid   <= 1'b1;
               req_ch.rx_byte <= rx_byte_q.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Frame monitor: every accepted frame is checked against the oldest prediction.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (frame_expect_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected frame, status %0d body %h", $time,
                        rsp_ch.frame_status, rsp_ch.frame_body);
            end else begin
               oldest_frame = frame_expect_q.pop_front();
               if (rsp_ch.frame_status !== oldest_frame.status) begin
                  error_count++;
                  $display("%0t: frame_status expected %0d actual %0d", $time,
                           oldest_frame.status, rsp_ch.frame_status);
               end
               if (rsp_ch.frame_body !== oldest_frame.body) begin
                  error_count++;
                  $display("%0t: frame_body expected %h actual %h", $time,
                           oldest_frame.body, rsp_ch.frame_body);
               end
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Queues bytes first..last-1 of a frame. A bad check byte differs from the true XOR.
   task automatic queue_frame(input byte_type sync_byte, input body_type body,
                              input int first, input int last, input bit bad_check);
      byte_type frame_bytes [FRAME_BYTES];
      byte_type sum;
      frame_bytes[0] = sync_byte;
      sum = sync_byte;
      for (int i = 1; i < FRAME_BYTES - 1; i++) begin
         frame_bytes[i] = body[(FRAME_BYTES - 2 - i) * 8 +: 8];
         sum = sum ^ frame_bytes[i];
      end
      frame_bytes[FRAME_BYTES - 1] =
         bad_check ? sum ^ byte_type'($urandom_range(255, 1)) : sum;
      for (int i = first; i < last; i++)
         rx_byte_q.push_back(frame_bytes[i]);
      framed_items += last - first;
   endtask

   // The receiver may still hold a partial frame, so allow its pipeline to settle.
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (rx_byte_q.size() != 0 || req_ch.valid || frame_expect_q.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_sync(input byte_type value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(negedge clock);
   endtask

   function automatic byte_type pick_data_byte(input byte_type sync_byte);
      case ($urandom_range(9))
         0:       return sync_byte;
         1:       return 8'h00;
         2:       return 8'hFF;
         default: return byte_type'($urandom_range(255));
      endcase
   endfunction

   initial begin
      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_wr_data    <= '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      framed_items   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Noise while hunting, then a good frame, a bad one, and a sync byte inside a body.
      rx_byte_q.push_back(8'h00);
      rx_byte_q.push_back(8'hFF);
      queue_frame(SYNC_RESET, 40'hFF_00_C1_80_01, 0, FRAME_BYTES, 1'b0);
      queue_frame(SYNC_RESET, 40'h00_00_00_00_00, 0, FRAME_BYTES, 1'b1);

      // A new sync value written mid-frame must not disturb the frame in progress.
      queue_frame(SYNC_RESET, 40'h12_34_56_78_9A, 0, 3, 1'b0);
      wait_until_idle();
      write_sync(8'h00);
      queue_frame(SYNC_RESET, 40'h12_34_56_78_9A, 3, FRAME_BYTES, 1'b0);
      queue_frame(8'h00, 40'hFF_FF_FF_FF_FF, 0, FRAME_BYTES, 1'b0);

      for (int p = 0; p < 4; p++) begin
         wait_until_idle();
         case (p)
            0:       phase_sync = 8'hFF;
            1:       phase_sync = 8'h00;
            2:       phase_sync = byte_type'($urandom_range(255));
            default: phase_sync = SYNC_RESET;
         endcase
         write_sync(phase_sync);
         send_idle_pct  = (p == 1) ? 64 : (p == 3) ? 32 : 0;
         recv_stall_pct = (p == 2) ? 64 : (p == 3) ? 32 : 0;
         phase_start = framed_items;
         while (framed_items - phase_start < PHASE_ITEMS) begin
            choice = $urandom_range(99);
            rand_body = '0;
            for (int j = 0; j < FRAME_BYTES - 2; j++)
               rand_body = body_type'({rand_body, pick_data_byte(phase_sync)});
            if (choice < 80)
               queue_frame(phase_sync, rand_body, 0, FRAME_BYTES, $urandom_range(3) == 0);
            else if (choice < 90)
               queue_frame(phase_sync, rand_body, 0, $urandom_range(FRAME_BYTES - 1, 1),
                           1'b0);
            else
               repeat ($urandom_range(4, 1))
                  rx_byte_q.push_back(byte_type'($urandom_range(255)));
            if ($urandom_range(39) == 0)
               wait_until_idle();
            while (rx_byte_q.size() > 32)
               @(negedge clock);
         end
      end

      wait_until_idle();
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire
